[rtl/core/tbsa_pkg.sv]
// token bucket send admission: shared types, codes and constants
// used by every module of the block; depends on nothing
package tbsa_pkg;

  // field widths
  localparam int TIME_W   = 32;
  localparam int TOK_W    = 12;
  localparam int PERIOD_W = 16;
  localparam int MAXW_W   = 16;
  localparam int LEN_W    = 8;
  localparam int CHARGE_W = LEN_W + 1;
  localparam int SPACE_W  = 12;
  localparam int PROD_W   = CHARGE_W + PERIOD_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CAP    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PER    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAXW   = 2'd3;

  // register reset values
  localparam logic [TOK_W-1:0]    CAP_RESET    = 12'd200;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [TOK_W-1:0]    PER_RESET    = 12'd50;
  localparam logic [MAXW_W-1:0]   MAXW_RESET   = 16'd3000;

  localparam logic [TIME_W-1:0] WAIT_SAT = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0]  CHARGE_EXTRA = 8'd2;

  typedef enum logic [2:0] {
    ST_SENT         = 3'd0,
    ST_WAITED       = 3'd1,
    ST_DROP_LONG    = 3'd2,
    ST_DROP_NODELAY = 3'd3,
    ST_TX_FULL      = 3'd4,
    ST_FLUSHED      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIN_SEND,
    FIN_FLUSH,
    FIN_DROP_NODELAY,
    FIN_DROP_LONG
  } fin_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REFILL1,
    S_CHECK,
    S_REFILL2,
    S_SHORT2,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WCHK,
    S_REFILL3,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [SPACE_W-1:0] tx_space;
    logic               can_delay;
    logic               is_priority;
    logic [LEN_W-1:0]   text_len;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [TOK_W-1:0]  tokens_left;
    logic [TIME_W-1:0] wait_ms;
    status_t           status;
    logic              sent;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      refill;
    logic      wait_sat;
    logic      mul;
    logic      div_start;
    logic      wait_load;
    logic      wait_time;
    logic      fin;
    fin_code_t code;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic prio;
    logic may_wait;
    logic lacking;
    logic per_zero;
    logic div_done;
    logic wait_ok;
    logic out_free;
  } stat_t;

endpackage

[rtl/core/token_bucket_send_admission_top.sv]
// token bucket send admission, top level: stream ports, config port,
// controller and datapath; depends on tbsa_pkg, tbsa_ctrl, tbsa_dp
// steps: a flush or priority send goes from decode to finish; a covered send first takes a
// refill and a check; a waiting send adds a second refill, the multiply, the divider and a third
// refill. One item in flight; the next beat may be taken while the last result awaits the sink
// reset: bucket full at 200 tokens, last refill time 0, registers 200/1000/50/3000
module token_bucket_send_admission_top (
  input  logic                             clk,
  input  logic                             rst,
  // config write port
  input  logic                             cfg_we,
  input  logic [tbsa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tbsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request beats
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms[31:0], text_len[39:32], is_priority[40], can_delay[41],
  // tx_space[53:42], zero pad[55:54]
  input  logic [tbsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[0]: 0 send request, 1 flush
  input  logic                             s_axis_tuser,
  // result beats
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sent[0], status[3:1], wait_ms[35:4], tokens_left[47:36]
  output logic [tbsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import tbsa_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  cmd_t      cmd;
  stat_t     stat;

  // unpack the request beat; the pad bits are ignored
  assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

  tbsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // the result register inside the datapath lets the next request in
  // while a finished result still waits for the sink
  tbsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_kind   (s_axis_tuser),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = out_item;

  // an accepted beat keeps the block busy on the next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !s_axis_tready)
    else $error("request taken while an item is still being worked");

  // the divider only finishes while an item is in progress
  a_div_in_item: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> !s_axis_tready)
    else $error("divider finished with no item in progress");

  // a flush always reports flushed on the next result
  a_flush_status: assert property (@(posedge clk) disable iff (rst)
    cmd.fin && (cmd.code == FIN_FLUSH) |=> m_axis_tvalid && (out_item.status == ST_FLUSHED))
    else $error("flush did not report flushed");

  // a sent message is reported as sent or sent after wait
  a_sent_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_item.sent |->
      (out_item.status == ST_SENT) || (out_item.status == ST_WAITED))
    else $error("sent flag with a drop status");

endmodule

[rtl/core/tbsa_div.sv]
// restoring divider, one quotient bit per cycle, for the wait time
// depends on tbsa_pkg
module tbsa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tbsa_pkg::PROD_W-1:0]  dividend,
  input  logic [tbsa_pkg::TOK_W-1:0]   divisor,
  output logic                         done,
  output logic [tbsa_pkg::PROD_W-1:0]  quotient
);
  import tbsa_pkg::*;

  logic [PROD_W-1:0]    quo;
  logic [TOK_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [TOK_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quo[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(PROD_W - 1);
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        else cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[PROD_W-2:0], fits};
      rem <= fits ? TOK_W'(trial - {1'b0, divisor}) : trial[TOK_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

[rtl/core/tbsa_dp.sv]
// datapath: config registers, bucket state, item registers, wait arithmetic
// and the result register; depends on tbsa_pkg and tbsa_div
module tbsa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tbsa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tbsa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_kind,
  input  tbsa_pkg::in_item_t              in_item,
  input  tbsa_pkg::cmd_t                  cmd,
  output tbsa_pkg::stat_t                 stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tbsa_pkg::out_item_t             out_item
);
  import tbsa_pkg::*;

  // config
  logic [TOK_W-1:0]    cap;
  logic [PERIOD_W-1:0] period;
  logic [TOK_W-1:0]    per;
  logic [MAXW_W-1:0]   maxw;

  // bucket state
  logic [TOK_W-1:0]  token, token_next;
  logic [TIME_W-1:0] last, last_next;

  // item
  logic                kind;
  logic [TIME_W-1:0]   t_r;
  logic [CHARGE_W-1:0] charge;
  logic                prio;
  logic                may_wait;
  logic [SPACE_W-1:0]  space;
  logic                waited;
  logic [TIME_W-1:0]   wait_r;
  logic [PROD_W-1:0]   prod;

  logic [TIME_W-1:0]   elapsed;
  logic                refill_due;
  logic [TOK_W:0]      sum;
  logic [TOK_W-1:0]    refill_cnt;
  logic [TOK_W-1:0]    charge_ext;
  logic [TOK_W-1:0]    shortfall;
  logic                space_ok;
  logic                div_done;
  logic [PROD_W-1:0]   quotient;
  out_item_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= CAP_RESET;
      period <= PERIOD_RESET;
      per    <= PER_RESET;
      maxw   <= MAXW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAP:    cap    <= cfg_data[TOK_W-1:0];
        REG_PERIOD: period <= cfg_data[PERIOD_W-1:0];
        REG_PER:    per    <= cfg_data[TOK_W-1:0];
        REG_MAXW:   maxw   <= cfg_data[MAXW_W-1:0];
      endcase
    end
  end

  assign charge_ext = {{(TOK_W-CHARGE_W){1'b0}}, charge};
  assign elapsed    = t_r - last;
  assign refill_due = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period};
  assign sum        = {1'b0, token} + {1'b0, per};
  assign refill_cnt = (sum < {1'b0, cap}) ? sum[TOK_W-1:0] : cap;
  assign space_ok   = space >= charge_ext;
  assign shortfall  = charge_ext - token;

  // bucket update
  always_comb begin
    token_next = token;
    last_next  = last;
    if (cmd.refill && refill_due) begin
      token_next = refill_cnt;
      last_next  = t_r;
    end
    if (cmd.fin) begin
      unique case (cmd.code)
        FIN_FLUSH: begin
          token_next = cap;
          last_next  = t_r;
        end
        FIN_SEND: begin
          if (space_ok && !prio && !stat.lacking) token_next = token - charge_ext;
        end
        FIN_DROP_NODELAY, FIN_DROP_LONG: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= CAP_RESET;
      last  <= '0;
    end else begin
      token <= token_next;
      last  <= last_next;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= in_kind;
      t_r      <= in_item.now_ms;
      charge   <= CHARGE_W'(in_item.text_len) + CHARGE_W'(CHARGE_EXTRA);
      prio     <= in_item.is_priority;
      may_wait <= in_item.can_delay;
      space    <= in_item.tx_space;
      waited   <= 1'b0;
      wait_r   <= '0;
    end else begin
      if (cmd.wait_sat)  wait_r <= WAIT_SAT;
      if (cmd.wait_load) wait_r <= TIME_W'(quotient);
      if (cmd.wait_time) begin
        t_r    <= t_r + wait_r;
        waited <= 1'b1;
      end
    end
    if (cmd.mul) prod <= PROD_W'(shortfall[CHARGE_W-1:0] * period);
  end

  tbsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (per),
    .done     (div_done),
    .quotient (quotient)
  );

  // result fields
  always_comb begin
    res.tokens_left = token_next;
    res.wait_ms     = wait_r;
    res.sent        = 1'b0;
    res.status      = ST_SENT;
    unique case (cmd.code)
      FIN_FLUSH: begin
        res.status = ST_FLUSHED;
        res.wait_ms = '0;
      end
      FIN_SEND: begin
        if (!space_ok) res.status = ST_TX_FULL;
        else begin
          res.sent   = 1'b1;
          res.status = waited ? ST_WAITED : ST_SENT;
        end
      end
      FIN_DROP_NODELAY: res.status = ST_DROP_NODELAY;
      FIN_DROP_LONG:    res.status = ST_DROP_LONG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.fin) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_item <= res;
  end

  assign stat.kind     = kind;
  assign stat.prio     = prio;
  assign stat.may_wait = may_wait;
  assign stat.lacking  = token < charge_ext;
  assign stat.per_zero = per == '0;
  assign stat.div_done = div_done;
  assign stat.wait_ok  = (wait_r != '0) && (wait_r < {{(TIME_W-MAXW_W){1'b0}}, maxw});
  assign stat.out_free = !out_valid || out_ready;

endmodule

[rtl/core/tbsa_ctrl.sv]
// controller: sequences refill tests, the wait computation and the result
// depends on tbsa_pkg
module tbsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tbsa_pkg::stat_t stat,
  output tbsa_pkg::cmd_t  cmd
);
  import tbsa_pkg::*;

  state_t    state, state_next;
  fin_code_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= FIN_SEND;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    code_next  = code;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        priority if (stat.kind) begin
          code_next = FIN_FLUSH; state_next = S_FINISH;
        end else if (stat.prio) begin
          code_next = FIN_SEND; state_next = S_FINISH;
        end else state_next = S_REFILL1;
      end
      S_REFILL1: state_next = S_CHECK;
      S_CHECK: begin
        priority if (!stat.lacking) begin
          code_next = FIN_SEND; state_next = S_FINISH;
        end else if (!stat.may_wait) begin
          code_next = FIN_DROP_NODELAY; state_next = S_FINISH;
        end else state_next = S_REFILL2;
      end
      S_REFILL2: state_next = S_SHORT2;
      S_SHORT2: begin
        if (!stat.lacking || stat.per_zero) begin
          code_next = FIN_DROP_LONG; state_next = S_FINISH;
        end else state_next = S_DIV_GO;
      end
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (stat.div_done) state_next = S_WCHK;
      S_WCHK: begin
        if (stat.wait_ok) state_next = S_REFILL3;
        else begin
          code_next = FIN_DROP_LONG; state_next = S_FINISH;
        end
      end
      S_REFILL3: begin
        code_next = FIN_SEND; state_next = S_FINISH;
      end
      S_FINISH: if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.code = code;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_REFILL1, S_REFILL2, S_REFILL3: cmd.refill = 1'b1;
      S_SHORT2: begin
        cmd.wait_sat = stat.lacking && stat.per_zero;
        cmd.mul      = stat.lacking && !stat.per_zero;
      end
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.wait_load = stat.div_done;
      S_WCHK:     cmd.wait_time = stat.wait_ok;
      S_FINISH:   cmd.fin = stat.out_free;
      S_DECODE, S_CHECK: ;
      default: ;
    endcase
  end

endmodule
